// ===== rtl/pagp_pkg.sv =====
// ----------------------------------------------------------------------------
// pagp_pkg: shared types and constants for positional gain and pan
// Widths of the serial arithmetic units, output limits and controller states.
// ----------------------------------------------------------------------------
`default_nettype none

package pagp_pkg;

	// Magnitude and operand width of the serial multiplier and divider.
	localparam int MUL_W  = 16;
	localparam int PROD_W = 2 * MUL_W;
	// Sum of three squared 16-bit magnitudes.
	localparam int D2_W   = PROD_W + 2;
	// Floor root of a D2_W-bit value and its working remainder.
	localparam int ROOT_W = D2_W / 2;
	localparam int REM_W  = ROOT_W + 3;

	localparam logic [MUL_W-1:0]   GAIN_ONE    = 16'd32768;
	localparam logic [MUL_W:0]     VOL_MAX     = 17'd32768;
	localparam logic [MUL_W-1:0]   PAN_POS_MAX = 16'd32767;
	localparam logic [MUL_W-1:0]   PAN_NEG_MAX = 16'd32768;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_LOAD,
		ST_SQ,
		ST_SUM,
		ST_CMP,
		ST_ROOT,
		ST_DIVW,
		ST_VOL,
		ST_OUT
	} pagp_state_t;

endpackage

`default_nettype wire

// ===== rtl/pagp_in_if.sv =====
// ----------------------------------------------------------------------------
// pagp_in_if: input channel of positional gain and pan
// Valid/ready channel carrying one source and listener position per transaction.
// ----------------------------------------------------------------------------
`default_nettype none

interface pagp_in_if;
	logic               valid;
	logic               ready;
	logic        [5:0]  source_index;
	logic signed [15:0] source_x;
	logic signed [15:0] source_y;
	logic signed [15:0] source_z;
	logic signed [15:0] listener_x;
	logic signed [15:0] listener_y;
	logic signed [15:0] listener_z;
	logic        [15:0] inner_radius;
	logic        [15:0] outer_radius;
	logic        [15:0] base_volume;

	modport source (
		output valid, source_index, source_x, source_y, source_z,
		       listener_x, listener_y, listener_z, inner_radius, outer_radius, base_volume,
		input  ready
	);
	modport sink (
		input  valid, source_index, source_x, source_y, source_z,
		       listener_x, listener_y, listener_z, inner_radius, outer_radius, base_volume,
		output ready
	);
endinterface

`default_nettype wire

// ===== rtl/pagp_out_if.sv =====
// ----------------------------------------------------------------------------
// pagp_out_if: result channel of positional gain and pan
// Valid/ready channel carrying pan, volume and zone flags per transaction.
// ----------------------------------------------------------------------------
`default_nettype none

interface pagp_out_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] pan_out;
	logic        [15:0] volume_out;
	logic               now_inside;
	logic               just_entered;

	modport source (
		output valid, pan_out, volume_out, now_inside, just_entered,
		input  ready
	);
	modport sink (
		input  valid, pan_out, volume_out, now_inside, just_entered,
		output ready
	);
endinterface

`default_nettype wire

// ===== rtl/pagp_mul.sv =====
// ----------------------------------------------------------------------------
// pagp_mul: bit-serial unsigned multiplier
// Shift-and-add over one multiplier bit per cycle; product held until restart.
// ----------------------------------------------------------------------------
`default_nettype none

module pagp_mul
	import pagp_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	input  wire logic [MUL_W-1:0]  a,
	input  wire logic [MUL_W-1:0]  b,
	output logic                   busy,
	output logic [PROD_W-1:0]      prod
);

	localparam int CNT_W = $clog2(MUL_W);

	logic [MUL_W-1:0]  a_q;
	logic [PROD_W-1:0] p_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              busy_q;
	logic [MUL_W:0]    sum;

	// The low half starts as the multiplier and drains out as the product fills in.
	assign sum = {1'b0, p_q[PROD_W-1:MUL_W]} + (p_q[0] ? {1'b0, a_q} : {(MUL_W+1){1'b0}});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == CNT_W'(MUL_W - 1))
				busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q <= a;
			p_q <= {{MUL_W{1'b0}}, b};
		end else if (busy_q) begin
			p_q <= {sum, p_q[MUL_W-1:1]};
		end
	end

	assign busy = busy_q;
	assign prod = p_q;

endmodule

`default_nettype wire

// ===== rtl/pagp_sqrt.sv =====
// ----------------------------------------------------------------------------
// pagp_sqrt: digit-serial floor square root
// Consumes two radicand bits per cycle and produces one root bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module pagp_sqrt
	import pagp_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	input  wire logic [D2_W-1:0]   radicand,
	output logic                   busy,
	output logic [ROOT_W-1:0]      root
);

	localparam int CNT_W = $clog2(ROOT_W);

	logic [D2_W-1:0]   rad_q;
	logic [REM_W-1:0]  rem_q;
	logic [ROOT_W-1:0] root_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              busy_q;
	logic [REM_W-1:0]  rem_sh;
	logic [REM_W-1:0]  trial;
	logic              take;

	assign rem_sh = {rem_q[REM_W-3:0], rad_q[D2_W-1:D2_W-2]};
	assign trial  = {1'b0, root_q, 2'b01};
	assign take   = rem_sh >= trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == CNT_W'(ROOT_W - 1))
				busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rad_q  <= radicand;
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			rad_q  <= {rad_q[D2_W-3:0], 2'b00};
			rem_q  <= take ? (rem_sh - trial) : rem_sh;
			root_q <= {root_q[ROOT_W-2:0], take};
		end
	end

	assign busy = busy_q;
	assign root = root_q;

endmodule

`default_nettype wire

// ===== rtl/pagp_div.sv =====
// ----------------------------------------------------------------------------
// pagp_div: bit-serial restoring divider for Q1.15 ratios
// Computes floor((num * 32768) / den) one quotient bit per cycle, for num < 2*den.
// ----------------------------------------------------------------------------
`default_nettype none

module pagp_div
	import pagp_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	input  wire logic [MUL_W-1:0]  num,
	input  wire logic [MUL_W-1:0]  den,
	output logic                   busy,
	output logic [MUL_W-1:0]       quot
);

	localparam int CNT_W = $clog2(MUL_W);

	logic [MUL_W-1:0] r_q;
	logic [MUL_W-1:0] nq_q;
	logic [MUL_W-1:0] d_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic [MUL_W:0]   r2;
	logic [MUL_W:0]   diff;
	logic             take;

	// nq_q shifts the remaining dividend bits out at the top and the
	// quotient bits in at the bottom.
	assign r2   = {r_q, nq_q[MUL_W-1]};
	assign diff = r2 - {1'b0, d_q};
	assign take = r2 >= {1'b0, d_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == CNT_W'(MUL_W - 1))
				busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			r_q  <= {1'b0, num[MUL_W-1:1]};
			nq_q <= {num[0], {(MUL_W-1){1'b0}}};
			d_q  <= den;
		end else if (busy_q) begin
			r_q  <= take ? diff[MUL_W-1:0] : r2[MUL_W-1:0];
			nq_q <= {nq_q[MUL_W-2:0], take};
		end
	end

	assign busy = busy_q;
	assign quot = nq_q;

endmodule

`default_nettype wire

// ===== rtl/positional_audio_gain_pan.sv =====
// ----------------------------------------------------------------------------
// positional_audio_gain_pan: distance attenuation and pan for one sound source
// Each input transaction carries a source and a listener position, two radii
// and a base volume; each yields one result transaction with pan, volume and
// zone flags. Both channels use valid/ready.
// One item is processed at a time. The input is ready only while the block is
// idle, and the next item may be taken while a finished result still sits in
// the output register. When the distance lies between the radii, the squares,
// root, gain division and volume multiply run back to back on bit-serial
// units; otherwise the root and gain division are skipped.
// If the receiver stalls, the finished result waits in the output register
// and the controller holds in its last state until the register frees up.
// Reset clears the controller, the output valid and every per-source inside
// flag at once; there is no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module positional_audio_gain_pan
	import pagp_pkg::*;
#(
	parameter int NUM_SOURCES = 64
) (
	input  wire logic     clk,
	input  wire logic     arst_n,
	pagp_in_if.sink       items,
	pagp_out_if.source    results
);

	// Only indexes reachable by the 6-bit source index need a flag.
	localparam int NF = (NUM_SOURCES < 64) ? NUM_SOURCES : 64;
	localparam int IW = (NF > 1) ? $clog2(NF) : 1;

	pagp_state_t state_q, state_d;

	logic [MUL_W-1:0] mag_x_q, mag_y_q, mag_z_q;
	logic             neg_x_q;
	logic [MUL_W-1:0] inner_q, outer_q, base_q;
	logic [5:0]       idx_q;
	logic [D2_W-1:0]  d2_q;
	logic             ramp_q, now_in_q, pan_sat_q;
	logic [MUL_W-1:0] gain_q;
	logic [NF-1:0]    flags_q;

	logic               out_valid_q;
	logic signed [15:0] pan_q;
	logic [15:0]        vol_q;
	logic               inside_q, entered_q;

	// Capture-side arithmetic
	logic [MUL_W:0]   dx, dy, dz, ax, ay, az;
	logic             swap;
	logic [MUL_W-1:0] r_hi, r_lo;

	// Unit handshakes
	logic [4:0]        mul_start, mul_busy;
	logic [MUL_W-1:0]  mul_a [5];
	logic [MUL_W-1:0]  mul_b [5];
	logic [PROD_W-1:0] mul_p [5];
	logic              sqrt_start, sqrt_busy;
	logic [ROOT_W-1:0] root;
	logic              pdiv_start, pdiv_busy, gdiv_start, gdiv_busy;
	logic [MUL_W-1:0]  pquot, gquot;

	logic              accept, load_out, start_sq, start_vol;
	logic              ramp_now, full_now;
	logic [MUL_W-1:0]  dist_c, gnum, gden, gain_sel;
	logic [MUL_W:0]    vol17;
	logic [15:0]       vol_sat, pan_mag;
	logic signed [15:0] pan_val;
	logic              in_range, was_in;

	assign accept = items.valid && items.ready;
	assign items.ready = (state_q == ST_IDLE);

	assign dx = {items.source_x[15], items.source_x} - {items.listener_x[15], items.listener_x};
	assign dy = {items.source_y[15], items.source_y} - {items.listener_y[15], items.listener_y};
	assign dz = {items.source_z[15], items.source_z} - {items.listener_z[15], items.listener_z};
	assign ax = dx[MUL_W] ? ((MUL_W+1)'(0) - dx) : dx;
	assign ay = dy[MUL_W] ? ((MUL_W+1)'(0) - dy) : dy;
	assign az = dz[MUL_W] ? ((MUL_W+1)'(0) - dz) : dz;

	assign swap = items.outer_radius < items.inner_radius;
	assign r_hi = swap ? items.inner_radius : items.outer_radius;
	assign r_lo = swap ? items.outer_radius : items.inner_radius;

	always_ff @(posedge clk) begin
		if (accept) begin
			mag_x_q <= ax[MUL_W-1:0];
			mag_y_q <= ay[MUL_W-1:0];
			mag_z_q <= az[MUL_W-1:0];
			neg_x_q <= dx[MUL_W];
			inner_q <= r_lo;
			outer_q <= (r_hi == '0) ? MUL_W'(1) : r_hi;
			base_q  <= items.base_volume;
			idx_q   <= items.source_index;
		end
	end

	// Lane 0 squares dx and later forms base volume times gain.
	assign start_sq  = (state_q == ST_LOAD);
	assign gain_sel  = ramp_q ? gquot : gain_q;
	assign mul_a[0]  = start_sq ? mag_x_q : base_q;
	assign mul_b[0]  = start_sq ? mag_x_q : gain_sel;
	assign mul_a[1]  = mag_y_q;
	assign mul_b[1]  = mag_y_q;
	assign mul_a[2]  = mag_z_q;
	assign mul_b[2]  = mag_z_q;
	assign mul_a[3]  = inner_q;
	assign mul_b[3]  = inner_q;
	assign mul_a[4]  = outer_q;
	assign mul_b[4]  = outer_q;
	assign mul_start = {{4{start_sq}}, start_sq || start_vol};

	for (genvar i = 0; i < 5; i++) begin : g_lane
		pagp_mul u_mul (
			.clk    (clk),
			.arst_n (arst_n),
			.start  (mul_start[i]),
			.a      (mul_a[i]),
			.b      (mul_b[i]),
			.busy   (mul_busy[i]),
			.prod   (mul_p[i])
		);
	end

	pagp_sqrt u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (sqrt_start),
		.radicand (d2_q),
		.busy     (sqrt_busy),
		.root     (root)
	);

	pagp_div u_pan_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (pdiv_start),
		.num    (mag_x_q),
		.den    (outer_q),
		.busy   (pdiv_busy),
		.quot   (pquot)
	);

	// Within the ramp the root is below the outer radius, so it fits MUL_W bits.
	assign dist_c = (root < {1'b0, inner_q}) ? inner_q : root[MUL_W-1:0];
	assign gnum   = outer_q - dist_c;
	assign gden   = outer_q - inner_q;

	pagp_div u_gain_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (gdiv_start),
		.num    (gnum),
		.den    (gden),
		.busy   (gdiv_busy),
		.quot   (gquot)
	);

	assign full_now = d2_q <= {2'b00, mul_p[3]};
	assign ramp_now = !full_now && (d2_q < {2'b00, mul_p[4]});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

	always_comb begin
		state_d    = state_q;
		sqrt_start = 1'b0;
		pdiv_start = 1'b0;
		gdiv_start = 1'b0;
		start_vol  = 1'b0;
		load_out   = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (accept)
					state_d = ST_LOAD;
			end
			ST_LOAD: begin
				state_d = ST_SQ;
			end
			ST_SQ: begin
				if (!mul_busy[0])
					state_d = ST_SUM;
			end
			ST_SUM: begin
				state_d = ST_CMP;
			end
			ST_CMP: begin
				pdiv_start = 1'b1;
				sqrt_start = ramp_now;
				state_d    = ramp_now ? ST_ROOT : ST_DIVW;
			end
			ST_ROOT: begin
				if (!sqrt_busy) begin
					gdiv_start = 1'b1;
					state_d    = ST_DIVW;
				end
			end
			ST_DIVW: begin
				if (!pdiv_busy && !gdiv_busy) begin
					start_vol = 1'b1;
					state_d   = ST_VOL;
				end
			end
			ST_VOL: begin
				if (!mul_busy[0])
					state_d = ST_OUT;
			end
			ST_OUT: begin
				if (!out_valid_q || results.ready) begin
					load_out = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_SUM)
			d2_q <= D2_W'(mul_p[0]) + D2_W'(mul_p[1]) + D2_W'(mul_p[2]);
		if (state_q == ST_CMP) begin
			ramp_q    <= ramp_now;
			now_in_q  <= d2_q <= {2'b00, mul_p[4]};
			gain_q    <= full_now ? GAIN_ONE : '0;
			// The pan ratio reaches 2.0 or more exactly when |dx| >= 2 * outer.
			pan_sat_q <= {1'b0, mag_x_q} >= {outer_q, 1'b0};
		end
	end

	assign vol17   = mul_p[0][PROD_W-1:MUL_W-1];
	assign vol_sat = (vol17 > VOL_MAX) ? VOL_MAX[15:0] : vol17[15:0];

	always_comb begin
		if (neg_x_q) begin
			pan_mag = (pan_sat_q || pquot > PAN_NEG_MAX) ? PAN_NEG_MAX : pquot;
			pan_val = signed'(16'd0 - pan_mag);
		end else begin
			pan_mag = (pan_sat_q || pquot > PAN_POS_MAX) ? PAN_POS_MAX : pquot;
			pan_val = signed'(pan_mag);
		end
	end

	assign in_range = {1'b0, idx_q} < 7'(NF);
	assign was_in   = in_range && flags_q[idx_q[IW-1:0]];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flags_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load_out) begin
				out_valid_q <= 1'b1;
				if (in_range)
					flags_q[idx_q[IW-1:0]] <= now_in_q;
			end else if (results.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			pan_q     <= pan_val;
			vol_q     <= vol_sat;
			inside_q  <= now_in_q;
			entered_q <= now_in_q && !was_in;
		end
	end

	assign results.valid        = out_valid_q;
	assign results.pan_out      = pan_q;
	assign results.volume_out   = vol_q;
	assign results.now_inside   = inside_q;
	assign results.just_entered = entered_q;

	a_vol_limit: assert property (@(posedge clk) disable iff (!arst_n)
		results.valid |-> results.volume_out <= VOL_MAX[15:0])
		else $error("volume above unity on the result channel");

	a_entered_inside: assert property (@(posedge clk) disable iff (!arst_n)
		results.valid && results.just_entered |-> results.now_inside)
		else $error("just_entered set for a source that is not inside");

	a_idle_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_IDLE |-> !(mul_busy[0] || sqrt_busy || pdiv_busy || gdiv_busy))
		else $error("arithmetic unit still busy while the controller is idle");

	a_load_from_out: assert property (@(posedge clk) disable iff (!arst_n)
		load_out |=> results.valid && state_q == ST_IDLE)
		else $error("result load did not present a transaction");

endmodule

`default_nettype wire
